// ----- sv/hps_pkg.sv -----
// Shared types and constants for the host/port splitter.
package hps_pkg;

	localparam int ROLE_W = 3;
	localparam int VERD_W = 2;
	localparam int ERR_W = 12;
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	typedef enum logic [2:0] {
		MODE_START   = 3'd0,
		MODE_HOST    = 3'd1,
		MODE_PORT    = 3'd2,
		MODE_BRACKET = 3'd3,
		MODE_SEP     = 3'd4,
		MODE_FAILED  = 3'd5
	} mode_t;

	typedef enum logic [ROLE_W-1:0] {
		ROLE_HOST     = 3'd0,
		ROLE_PORT     = 3'd1,
		ROLE_DELIM    = 3'd2,
		ROLE_REJECTED = 3'd3,
		ROLE_IGNORED  = 3'd4,
		ROLE_END      = 3'd5
	} role_t;

	typedef enum logic [VERD_W-1:0] {
		VERD_NONE   = 2'd0,
		VERD_OK     = 2'd1,
		VERD_FAILED = 2'd2
	} verdict_t;

	typedef enum logic [2:0] {
		CLS_ALNUM,
		CLS_LBRACK,
		CLS_RBRACK,
		CLS_COLON,
		CLS_STAR,
		CLS_DOTDASH,
		CLS_OTHER
	} cls_t;

	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_DASH   = 8'h2D;

	typedef struct packed {
		logic       is_end;
		logic [7:0] ch;
		cls_t       cls;
	} entry_t;

endpackage

// ----- sv/hps_front.sv -----
// Front end: accepts requests and tags each character with its class.
module hps_front (
	input  logic           kind,
	input  logic [7:0]     char_in,
	output hps_pkg::entry_t entry
);
	import hps_pkg::*;

	cls_t cls;

	always_comb begin
		case (char_in) inside
			[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]: cls = CLS_ALNUM;
			CH_LBRACK: cls = CLS_LBRACK;
			CH_RBRACK: cls = CLS_RBRACK;
			CH_COLON: cls = CLS_COLON;
			CH_STAR: cls = CLS_STAR;
			CH_DOT, CH_DASH: cls = CLS_DOTDASH;
			default: cls = CLS_OTHER;
		endcase
	end

	assign entry.is_end = kind;
	assign entry.ch = char_in;
	assign entry.cls = cls;

endmodule

// ----- sv/hps_queue.sv -----
// Short queue of classified requests between front and back ends.
module hps_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_en,
	input  hps_pkg::entry_t wr_data,
	output logic            full,
	input  logic            rd_en,
	output hps_pkg::entry_t rd_data,
	output logic            not_empty
);
	import hps_pkg::*;

	entry_t slot_q [QDEPTH];
	logic [QPTR_W:0] wr_ptr_q;
	logic [QPTR_W:0] rd_ptr_q;

	assign full = (wr_ptr_q[QPTR_W] != rd_ptr_q[QPTR_W]) &&
		(wr_ptr_q[QPTR_W-1:0] == rd_ptr_q[QPTR_W-1:0]);
	assign not_empty = (wr_ptr_q != rd_ptr_q);
	assign rd_data = slot_q[rd_ptr_q[QPTR_W-1:0]];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_q[wr_ptr_q[QPTR_W-1:0]] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (wr_en) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (rd_en) rd_ptr_q <= rd_ptr_q + 1'b1;
		end
	end

endmodule

// ----- sv/hps_back.sv -----
// Back end: parser state machine and the result register.
module hps_back #(
	parameter int MAX_LEN = 4096
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cmd_valid,
	input  hps_pkg::entry_t            cmd,
	output logic                       cmd_pop,
	output logic                       empty,
	input  logic                       pop,
	output logic [hps_pkg::ROLE_W-1:0] role,
	output logic [7:0]                 char_out,
	output logic [hps_pkg::VERD_W-1:0] verdict,
	output logic [hps_pkg::ERR_W-1:0]  error_index
);
	import hps_pkg::*;

	localparam int POS_W = (MAX_LEN > 2) ? $clog2(MAX_LEN) : 1;
	localparam logic [POS_W-1:0] POS_LAST = POS_W'(MAX_LEN - 1);

	mode_t mode_q, mode_d;
	logic [POS_W-1:0] pos_q;
	logic [POS_W-1:0] fail_q;
	logic port_seen_q;

	logic out_valid_q;
	role_t role_q;
	logic [7:0] char_q;
	verdict_t verd_q;
	logic [ERR_W-1:0] err_q;

	role_t role_d;
	verdict_t verd_d;
	logic [POS_W-1:0] idx_d;
	logic advance;

	assign advance = cmd_valid && (!out_valid_q || pop);
	assign cmd_pop = advance;

	// next mode
	always_comb begin
		mode_d = mode_q;
		if (cmd.is_end) begin
			mode_d = MODE_START;
		end else begin
			case (mode_q)
				MODE_START: begin
					case (cmd.cls)
						CLS_LBRACK: mode_d = MODE_BRACKET;
						CLS_ALNUM: mode_d = MODE_HOST;
						CLS_STAR: mode_d = MODE_SEP;
						default: mode_d = MODE_FAILED;
					endcase
				end
				MODE_SEP: mode_d = (cmd.cls == CLS_COLON) ? MODE_PORT : MODE_FAILED;
				MODE_HOST: begin
					case (cmd.cls)
						CLS_COLON: mode_d = MODE_PORT;
						CLS_ALNUM, CLS_DOTDASH: mode_d = MODE_HOST;
						default: mode_d = MODE_FAILED;
					endcase
				end
				MODE_BRACKET: begin
					case (cmd.cls)
						CLS_RBRACK: mode_d = MODE_SEP;
						CLS_ALNUM, CLS_COLON, CLS_DOTDASH: mode_d = MODE_BRACKET;
						default: mode_d = MODE_FAILED;
					endcase
				end
				MODE_PORT: mode_d = (cmd.cls == CLS_ALNUM) ? MODE_PORT : MODE_FAILED;
				default: mode_d = MODE_FAILED;
			endcase
		end
	end

	// result fields
	always_comb begin
		role_d = ROLE_IGNORED;
		verd_d = VERD_NONE;
		idx_d = '0;
		if (cmd.is_end) begin
			role_d = ROLE_END;
			verd_d = VERD_OK;
			if (mode_q == MODE_FAILED) begin
				verd_d = VERD_FAILED;
				idx_d = fail_q;
			end else if (mode_q == MODE_BRACKET || (mode_q == MODE_PORT && !port_seen_q)) begin
				// string ended early: blame the last character
				verd_d = VERD_FAILED;
				idx_d = (pos_q != '0) ? pos_q - 1'b1 : '0;
			end
		end else begin
			case (mode_q)
				MODE_START: begin
					case (cmd.cls)
						CLS_LBRACK: role_d = ROLE_DELIM;
						CLS_ALNUM, CLS_STAR: role_d = ROLE_HOST;
						default: role_d = ROLE_REJECTED;
					endcase
				end
				MODE_SEP: role_d = (cmd.cls == CLS_COLON) ? ROLE_DELIM : ROLE_REJECTED;
				MODE_HOST: begin
					case (cmd.cls)
						CLS_COLON: role_d = ROLE_DELIM;
						CLS_ALNUM, CLS_DOTDASH: role_d = ROLE_HOST;
						default: role_d = ROLE_REJECTED;
					endcase
				end
				MODE_BRACKET: begin
					case (cmd.cls)
						CLS_RBRACK: role_d = ROLE_DELIM;
						CLS_ALNUM, CLS_COLON, CLS_DOTDASH: role_d = ROLE_HOST;
						default: role_d = ROLE_REJECTED;
					endcase
				end
				MODE_PORT: role_d = (cmd.cls == CLS_ALNUM) ? ROLE_PORT : ROLE_REJECTED;
				default: role_d = ROLE_IGNORED;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_START;
			pos_q <= '0;
			fail_q <= '0;
			port_seen_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				mode_q <= mode_d;
				if (cmd.is_end) begin
					pos_q <= '0;
					fail_q <= '0;
					port_seen_q <= 1'b0;
				end else begin
					if (role_d == ROLE_REJECTED) fail_q <= pos_q;
					if (role_d == ROLE_PORT) port_seen_q <= 1'b1;
					if (pos_q < POS_LAST) pos_q <= pos_q + 1'b1;
				end
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			role_q <= role_d;
			char_q <= cmd.is_end ? 8'h00 : cmd.ch;
			verd_q <= verd_d;
			err_q <= ERR_W'(idx_d);
		end
	end

	assign empty = !out_valid_q;
	assign role = role_q;
	assign char_out = char_q;
	assign verdict = verd_q;
	assign error_index = err_q;

endmodule

// ----- sv/host_port_splitter.sv -----
// Top level of the streaming host:port splitter.
//
// Input side is a queue: drive kind/char_in and push; a request is taken on
// a clock edge with push high and full low. kind=0 carries one character of
// a "host:port" or "[host]:port" string, kind=1 ends the string.
// Result side is a queue too: while empty is low, role, char_out, verdict
// and error_index show the oldest result; pop high takes it.
// Every request yields exactly one result, in order. An accepted request is
// written into the request queue and is parsed into the result register
// when that register is empty or its result is being popped, and one
// request per cycle is sustained while pop keeps pace with the results.
// If the receiver stalls, results wait in the result register and requests
// collect in the four-entry queue; full rises once it is filled.
// Reset (arst_n low) empties both queues and returns the parser to its
// start state with position, failure index and port flag cleared.
// An end request also returns the parser to the start state.
module host_port_splitter #(
	parameter int MAX_LEN = 4096
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	output logic                       full,
	input  logic                       kind,
	input  logic [7:0]                 char_in,
	output logic                       empty,
	input  logic                       pop,
	output logic [hps_pkg::ROLE_W-1:0] role,
	output logic [7:0]                 char_out,
	output logic [hps_pkg::VERD_W-1:0] verdict,
	output logic [hps_pkg::ERR_W-1:0]  error_index
);
	import hps_pkg::*;

	entry_t in_entry;
	entry_t q_entry;
	logic q_full;
	logic q_valid;
	logic q_pop;

	hps_front u_front (
		.kind    (kind),
		.char_in (char_in),
		.entry   (in_entry)
	);

	hps_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (push && !q_full),
		.wr_data   (in_entry),
		.full      (q_full),
		.rd_en     (q_pop),
		.rd_data   (q_entry),
		.not_empty (q_valid)
	);

	hps_back #(
		.MAX_LEN (MAX_LEN)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (q_valid),
		.cmd         (q_entry),
		.cmd_pop     (q_pop),
		.empty       (empty),
		.pop         (pop),
		.role        (role),
		.char_out    (char_out),
		.verdict     (verdict),
		.error_index (error_index)
	);

	assign full = q_full;

endmodule
